### rtl/double_log_lut_approx_macros.svh
// Assertion macros for the log pipeline.
// Simulation builds get the checks; synthesis builds get empty bodies.
`ifndef DOUBLE_LOG_LUT_APPROX_MACROS_SVH
`define DOUBLE_LOG_LUT_APPROX_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define DLOG_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dlog check failed");
// Next-cycle implication.
`define DLOG_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dlog check failed");
`else
`define DLOG_ASSERT_IMP(label, ante, cons)
`define DLOG_ASSERT_NXT(label, ante, cons)
`endif
`endif

### rtl/dlog_pkg.sv
`timescale 1ns / 1ps
package dlog_pkg;

  // Table geometry: the top fraction bits select the bin.
  localparam int IDX_W    = 8;
  localparam int ROM_SIZE = 1 << IDX_W;

  // Fixed patterns and constants of binary64.
  localparam logic [63:0] QNAN_BITS    = 64'h7FF8000000000000;
  localparam logic [63:0] NEG_INF_BITS = 64'hFFF0000000000000;
  localparam logic [10:0] EXP_ALL_ONES = 11'h7FF;
  localparam logic [52:0] LN2_MANT     = 53'h162E42FEFA39EF;
  localparam logic signed [12:0] EXP_ZERO = -13'sd4096;

  // Unpacked operand: value = mant * 2^(exp-52); mant of zero means zero.
  typedef struct packed {
    logic              sign;
    logic signed [12:0] exp;
    logic [52:0]       mant;
  } flt_t;

  // Per-item data that rides alongside the arithmetic.
  typedef struct packed {
    logic        last;
    logic        spec;
    logic [63:0] spec_bits;
    flt_t        r;
  } side_t;

  typedef logic [63:0] rom_t [ROM_SIZE];

  // Quotient of two small positive integers, rounded to nearest even binary64.
  // Long division on integers keeps the table build free of real division.
  function automatic real rdiv(input int num, input int den);
    logic [127:0] nsh;
    logic [127:0] dnm;
    logic [127:0] rem;
    logic [127:0] q;
    logic [53:0]  rnd;
    logic [10:0]  bexp;
    logic         inc;
    int           sh;
    nsh = 128'(num);
    dnm = 128'(den);
    sh  = 0;
    while (nsh < (dnm << 54)) begin
      nsh = nsh << 1;
      sh++;
    end
    rem = '0;
    q   = '0;
    for (int i = 127; i >= 0; i--) begin
      rem = {rem[126:0], nsh[i]};
      if (rem >= dnm) begin
        rem  = rem - dnm;
        q[i] = 1'b1;
      end
    end
    // The quotient holds 55 bits: 53 kept, a guard bit and a sticky bit.
    inc  = q[1] & (q[0] | (rem != '0) | q[2]);
    rnd  = {1'b0, q[54:2]} + 54'(inc);
    bexp = 11'(1077 - sh);
    if (rnd[53]) begin
      rnd  = rnd >> 1;
      bexp = bexp + 11'd1;
    end
    return $bitstoreal({1'b0, bexp, rnd[51:0]});
  endfunction

  // ln(m0) of bin k through 2*atanh(s), s = (m0-1)/(m0+1), in binary64.
  function automatic real ln_near_one(input int k);
    real s;
    real s2;
    real p;
    s  = rdiv(2 * k + 1, 4 * ROM_SIZE + 2 * k + 1);
    s2 = s * s;
    p  = rdiv(1, 61);
    for (int j = 29; j >= 1; j--) begin
      p = p * s2 + rdiv(1, 2 * j + 1);
    end
    return 2.0 * s + 2.0 * s * s2 * p;
  endfunction

  function automatic rom_t build_log();
    rom_t t;
    for (int k = 0; k < ROM_SIZE; k++) begin
      t[k] = $realtobits(ln_near_one(k));
    end
    return t;
  endfunction

  // 1/m0 with m0 = (2N + 2k + 1) / 2N.
  function automatic rom_t build_inv();
    rom_t t;
    for (int k = 0; k < ROM_SIZE; k++) begin
      t[k] = $realtobits(rdiv(2 * ROM_SIZE, 2 * ROM_SIZE + 2 * k + 1));
    end
    return t;
  endfunction

  localparam rom_t ROM_LOG = build_log();
  localparam rom_t ROM_INV = build_inv();

  // Number of zeros above the highest set bit; zero input gives 0.
  function automatic logic [5:0] lzc64(input logic [63:0] v);
    logic [5:0] n;
    n = '0;
    for (int i = 0; i < 64; i++) begin
      if (v[i]) n = 6'(63 - i);
    end
    return n;
  endfunction

  // Round a word with bit 63 set to 53 bits, nearest even; bit 53 is the carry.
  function automatic logic [53:0] rne64(input logic [63:0] n);
    logic inc;
    inc = n[10] & ((|n[9:0]) | n[11]);
    return {1'b0, n[63:11]} + 54'(inc);
  endfunction

endpackage

### rtl/double_log_lut_approx.sv
`timescale 1ns / 1ps
`include "double_log_lut_approx_macros.svh"
// Channel   Dir  Handshake              Payload
// in_       in   in_tvalid/in_tready    in_tdata = value_bits, in_tlast
// out_      out  out_tvalid/out_tready  out_tdata = log_bits, out_tlast
//
// One item enters per cycle while the pipeline is not held; results leave in order.
// The depth is set by eight front stages (classify, normalize, table read,
// partial products, rounding, residual), two four-stage adders and the output register.
// Reset clears only the valid bits; the tables are constant logic.
// When a result waits untaken, the whole pipeline holds and in_tready falls.
module double_log_lut_approx (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // [63:0] value_bits
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // [63:0] log_bits
  output logic        out_tlast
);
  import dlog_pkg::*;

  logic en;

  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, v7_r, v8_r;
  side_t sd1_r, sd2_r, sd3_r, sd4_r, sd5_r, sd6_r, sd7_r, sd8_r;

  logic [63:0] x1_r;
  logic [5:0]  lz1_r;
  logic        sub1_r;
  logic [52:0] mm2_r, mm3_r;
  logic signed [11:0] e2_r;
  logic [52:0] mi3_r;
  logic [63:0] lb3_r;
  logic [63:0] q3_r, q4_r;
  logic        es3_r, es4_r;
  logic [53:0] hh4_r;
  logic [52:0] hl4_r, lh4_r;
  logic [51:0] ll4_r;
  logic [5:0]  lzq4_r;
  flt_t        lf4_r, lf5_r, lf6_r, lf7_r, lf8_r;
  logic [105:0] p5_r;
  flt_t        t5_r, t6_r, t7_r, t8_r;
  logic [53:0] mag6_r, mag7_r;
  logic        dn6_r, dn7_r;
  logic [5:0]  lzd7_r;

  logic        v9, v10;
  flt_t        sum9, sum10;
  side_t       sd9, sd10;

  logic        out_valid_r;
  logic [63:0] out_data_r;
  logic        out_last_r;
  logic        out_spec_r;

  // Whole-pipeline advance: the output slot is free or being taken.
  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;

  // Stage 1: classify the operand and pick the fixed answers.
  side_t      sd1_nxt;
  logic [10:0] ex_in;
  logic [51:0] fr_in;
  always_comb begin
    ex_in = in_tdata[62:52];
    fr_in = in_tdata[51:0];
    sd1_nxt.last      = in_tlast;
    sd1_nxt.spec      = 1'b1;
    sd1_nxt.spec_bits = in_tdata;
    sd1_nxt.r         = '0;
    if (ex_in == EXP_ALL_ONES) begin
      if (fr_in == '0 && in_tdata[63]) sd1_nxt.spec_bits = QNAN_BITS;
    end else if (ex_in == '0 && fr_in == '0) begin
      sd1_nxt.spec_bits = NEG_INF_BITS;
    end else if (in_tdata[63]) begin
      sd1_nxt.spec_bits = QNAN_BITS;
    end else begin
      sd1_nxt.spec = 1'b0;
    end
  end

  // Stage 2: normalize subnormals; unbias the exponent.
  logic [52:0] mm2_nxt;
  logic signed [11:0] e2_nxt;
  always_comb begin
    if (sub1_r) begin
      mm2_nxt = {1'b0, x1_r[51:0]} << (7'(lz1_r) + 7'd1);
      e2_nxt  = -12'sd1023 - $signed({6'b0, lz1_r});
    end else begin
      mm2_nxt = {1'b1, x1_r[51:0]};
      e2_nxt  = $signed({1'b0, x1_r[62:52]}) - 12'sd1023;
    end
  end

  // Stage 3: table reads and the exponent times ln 2.
  logic [IDX_W-1:0] idx2;
  logic [63:0]      inv_bits;
  logic [10:0]      ea2;
  always_comb begin
    idx2     = mm2_r[51 -: IDX_W];
    inv_bits = ROM_INV[idx2];
    ea2      = e2_r[11] ? 11'(-e2_r) : e2_r[10:0];
  end

  // Stage 5: round the exponent term to binary64.
  logic [63:0] qn;
  logic [53:0] qk;
  flt_t        t5_nxt;
  always_comb begin
    qn = q4_r << lzq4_r;
    qk = rne64(qn);
    t5_nxt.sign = es4_r;
    t5_nxt.exp  = 13'sd10 - $signed({7'b0, lzq4_r}) + $signed({12'b0, qk[53]});
    t5_nxt.mant = qk[53] ? {1'b1, 52'b0} : qk[52:0];
    if (q4_r == 64'h0) begin
      t5_nxt.sign = 1'b0;
      t5_nxt.exp  = EXP_ZERO;
      t5_nxt.mant = '0;
    end
  end

  // Stage 6: round m * inv, then subtract one (exact in this range).
  logic [52:0] keep;
  logic        g, st;
  logic [53:0] rk;
  logic [54:0] pfix;
  logic signed [55:0] dv;
  always_comb begin
    if (p5_r[105]) begin
      keep = p5_r[105:53];
      g    = p5_r[52];
      st   = |p5_r[51:0];
    end else begin
      keep = p5_r[104:52];
      g    = p5_r[51];
      st   = |p5_r[50:0];
    end
    rk   = {1'b0, keep} + 54'(g & (st | keep[0]));
    pfix = p5_r[105] ? {rk, 1'b0} : {1'b0, rk};
    dv   = $signed({1'b0, pfix}) - 56'sh20000000000000;
  end

  // Stage 8: the residual as an operand.
  logic [63:0] dn;
  flt_t        r8_nxt;
  always_comb begin
    dn = {10'b0, mag7_r} << lzd7_r;
    r8_nxt.sign = dn7_r;
    r8_nxt.exp  = 13'sd10 - $signed({7'b0, lzd7_r});
    r8_nxt.mant = dn[63:11];
    if (mag7_r == '0) begin
      r8_nxt.sign = 1'b0;
      r8_nxt.exp  = EXP_ZERO;
      r8_nxt.mant = '0;
    end
  end

  // Front pipeline payload registers.
  always_ff @(posedge clk) begin
    if (en) begin
      sd1_r  <= sd1_nxt;
      x1_r   <= in_tdata;
      lz1_r  <= lzc64({in_tdata[51:0], 12'b0});
      sub1_r <= (in_tdata[62:52] == '0);

      sd2_r <= sd1_r;
      mm2_r <= mm2_nxt;
      e2_r  <= e2_nxt;

      sd3_r <= sd2_r;
      mm3_r <= mm2_r;
      mi3_r <= {1'b1, inv_bits[51:0]};
      lb3_r <= ROM_LOG[idx2];
      q3_r  <= 64'(ea2) * 64'(LN2_MANT);
      es3_r <= e2_r[11];

      sd4_r  <= sd3_r;
      hh4_r  <= mm3_r[52:26] * mi3_r[52:26];
      hl4_r  <= mm3_r[52:26] * mi3_r[25:0];
      lh4_r  <= mm3_r[25:0] * mi3_r[52:26];
      ll4_r  <= mm3_r[25:0] * mi3_r[25:0];
      q4_r   <= q3_r;
      lzq4_r <= lzc64(q3_r);
      es4_r  <= es3_r;
      lf4_r.sign <= 1'b0;
      lf4_r.exp  <= $signed({2'b00, lb3_r[62:52]}) - 13'sd1023;
      lf4_r.mant <= {1'b1, lb3_r[51:0]};

      sd5_r <= sd4_r;
      p5_r  <= (106'(hh4_r) << 52) + (106'(hl4_r) << 26) + (106'(lh4_r) << 26)
               + 106'(ll4_r);
      t5_r  <= t5_nxt;
      lf5_r <= lf4_r;

      sd6_r  <= sd5_r;
      mag6_r <= dv[55] ? 54'(-dv) : dv[53:0];
      dn6_r  <= dv[55];
      t6_r   <= t5_r;
      lf6_r  <= lf5_r;

      sd7_r  <= sd6_r;
      mag7_r <= mag6_r;
      dn7_r  <= dn6_r;
      lzd7_r <= lzc64({10'b0, mag6_r});
      t7_r   <= t6_r;
      lf7_r  <= lf6_r;

      sd8_r.last      <= sd7_r.last;
      sd8_r.spec      <= sd7_r.spec;
      sd8_r.spec_bits <= sd7_r.spec_bits;
      sd8_r.r         <= r8_nxt;
      t8_r  <= t7_r;
      lf8_r <= lf7_r;
    end
  end

  // Front pipeline valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
      v7_r <= 1'b0;
      v8_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_tvalid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
      v7_r <= v6_r;
      v8_r <= v7_r;
    end
  end

  // t = e*ln2 + ln(m0).
  dlog_fadd u_add_t (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (v8_r),
    .a        (t8_r),
    .b        (lf8_r),
    .in_side  (sd8_r),
    .out_valid(v9),
    .out_sum  (sum9),
    .out_side (sd9)
  );

  // Result = t + r.
  dlog_fadd u_add_r (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (v9),
    .a        (sum9),
    .b        (sd9.r),
    .in_side  (sd9),
    .out_valid(v10),
    .out_sum  (sum10),
    .out_side (sd10)
  );

  // Pack the result or take the fixed answer.
  logic [12:0] be;
  logic [63:0] pack;
  always_comb begin
    be   = 13'(sum10.exp + 13'sd1023);
    pack = (sum10.mant == '0) ? 64'h0 : {sum10.sign, be[10:0], sum10.mant[51:0]};
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= v10;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= sd10.spec ? sd10.spec_bits : pack;
      out_last_r <= sd10.last;
      out_spec_r <= sd10.spec;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  // A held pipeline keeps its valid bits.
  `DLOG_ASSERT_NXT(a_hold_valids, !en, $stable({v1_r, v4_r, v8_r, out_valid_r}))
  // A computed result is always finite.
  `DLOG_ASSERT_IMP(a_finite, out_valid_r && !out_spec_r, out_data_r[62:52] != EXP_ALL_ONES)
  // The residual operand is normalized unless zero.
  `DLOG_ASSERT_IMP(a_r_norm, v8_r && (sd8_r.r.mant != '0), sd8_r.r.mant[52])

endmodule

### rtl/dlog_fadd.sv
`timescale 1ns / 1ps
module dlog_fadd (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           in_valid,
  input  dlog_pkg::flt_t a,
  input  dlog_pkg::flt_t b,
  input  dlog_pkg::side_t in_side,
  output logic           out_valid,
  output dlog_pkg::flt_t out_sum,
  output dlog_pkg::side_t out_side
);
  import dlog_pkg::*;

  logic        v1_r, v2_r, v3_r, v4_r;
  side_t       sd1_r, sd2_r, sd3_r, sd4_r;
  logic        sg1_r, sg2_r, sg3_r;
  logic signed [12:0] ex1_r, ex2_r, ex3_r;
  logic [52:0] mb1_r, ms1_r;
  logic [5:0]  sh1_r;
  logic        sub1_r;
  logic [63:0] sum2_r, sum3_r;
  logic [5:0]  lz3_r;
  flt_t        res4_r;

  flt_t        big, lesser;
  logic [13:0] diff;
  logic [63:0] a64, b64, bs, mask;
  logic [63:0] nrm;
  logic [53:0] rk;
  flt_t        res_nxt;

  // Order the operands by magnitude and find the alignment distance.
  always_comb begin
    if ((a.exp > b.exp) || ((a.exp == b.exp) && (a.mant >= b.mant))) begin
      big    = a;
      lesser = b;
    end else begin
      big    = b;
      lesser = a;
    end
    diff = {big.exp[12], big.exp} - {lesser.exp[12], lesser.exp};
  end

  // Align the smaller operand, fold the lost bits into a sticky bit, add.
  always_comb begin
    a64  = {1'b0, mb1_r, 10'b0};
    b64  = {1'b0, ms1_r, 10'b0};
    mask = (64'h1 << sh1_r) - 64'h1;
    bs   = b64 >> sh1_r;
    bs[0] = bs[0] | (|(b64 & mask));
  end

  // Normalize and round.
  always_comb begin
    nrm = sum3_r << lz3_r;
    rk  = rne64(nrm);
    res_nxt.sign = sg3_r;
    res_nxt.exp  = ex3_r + 13'sd1 - $signed({7'b0, lz3_r}) + $signed({12'b0, rk[53]});
    res_nxt.mant = rk[53] ? {1'b1, 52'b0} : rk[52:0];
    if (sum3_r == 64'h0) begin
      res_nxt.sign = 1'b0;
      res_nxt.exp  = EXP_ZERO;
      res_nxt.mant = '0;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (en) begin
      sd1_r  <= in_side;
      sg1_r  <= big.sign;
      ex1_r  <= big.exp;
      mb1_r  <= big.mant;
      ms1_r  <= lesser.mant;
      sh1_r  <= (|diff[13:6]) ? 6'd63 : diff[5:0];
      sub1_r <= a.sign ^ b.sign;
      sd2_r  <= sd1_r;
      sg2_r  <= sg1_r;
      ex2_r  <= ex1_r;
      sum2_r <= sub1_r ? (a64 - bs) : (a64 + bs);
      sd3_r  <= sd2_r;
      sg3_r  <= sg2_r;
      ex3_r  <= ex2_r;
      sum3_r <= sum2_r;
      lz3_r  <= lzc64(sum2_r);
      sd4_r  <= sd3_r;
      res4_r <= res_nxt;
    end
  end

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  assign out_valid = v4_r;
  assign out_sum   = res4_r;
  assign out_side  = sd4_r;

endmodule
